FILE: src/crre_pkg.sv
// Shared types and constants of the color range run extractor.
package crre_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COORD_W = 12;
    localparam int STOP_W  = 13;
    localparam int AREA_W  = 25;
    localparam int GAIN_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [COORD_W-1:0] COL_LAST = COORD_W'(MAX_WIDTH - 1);
    localparam logic [COORD_W-1:0] ROW_LAST = COORD_W'(MAX_HEIGHT - 1);
    localparam logic [AREA_W-1:0]  AREA_SAT = {AREA_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CH0_BOUNDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_BOUNDS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CH2_BOUNDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_WRAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA   = 3'd5;

    // result kinds
    localparam logic KIND_RUN     = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [15:0]       ch0_bounds;
        logic [15:0]       ch1_bounds;
        logic [15:0]       ch2_bounds;
        logic              hue_wrap;
        logic [GAIN_W-1:0] value_gain;
    } t_match_cfg;

    typedef struct packed {
        logic               last_of_item;
        logic               item_kind;
        logic               region_kept;
        logic [AREA_W-1:0]  frame_area;
        logic [STOP_W-1:0]  run_stop;
        logic [COORD_W-1:0] run_first;
        logic [COORD_W-1:0] run_row;
    } t_result;

endpackage

FILE: src/crre_pixel_match.sv
// Channel 2 gain scaling and per-channel bounds test of one pixel.
module crre_pixel_match (
    input  crre_pkg::t_match_cfg i_cfg,
    input  logic [7:0]           i_ch0,
    input  logic [7:0]           i_ch1,
    input  logic [7:0]           i_ch2,
    output logic                 o_hit
);

    logic [19:0] product;
    logic [20:0] rounded;
    logic [12:0] shifted;
    logic [7:0]  scaled;
    logic [7:0]  lo0, hi0, lo1, hi1, lo2, hi2;
    logic        ok0, ok1, ok2;

    always_comb begin
        product = 20'(i_ch2) * 20'(i_cfg.value_gain);
        rounded = 21'(product) + 21'd128;
        shifted = rounded[20:8];
        scaled  = (shifted > 13'd255) ? 8'd255 : shifted[7:0];

        lo0 = i_cfg.ch0_bounds[7:0];
        hi0 = i_cfg.ch0_bounds[15:8];
        lo1 = i_cfg.ch1_bounds[7:0];
        hi1 = i_cfg.ch1_bounds[15:8];
        lo2 = i_cfg.ch2_bounds[7:0];
        hi2 = i_cfg.ch2_bounds[15:8];

        // wrapping hue range: accept above min or below max
        if (i_cfg.hue_wrap && (lo0 > hi0)) begin
            ok0 = (i_ch0 >= lo0) || (i_ch0 <= hi0);
        end else begin
            ok0 = (i_ch0 >= lo0) && (i_ch0 <= hi0);
        end
        ok1 = (i_ch1 >= lo1) && (i_ch1 <= hi1);
        ok2 = (scaled >= lo2) && (scaled <= hi2);
        o_hit = ok0 && ok1 && ok2;
    end

endmodule

FILE: src/crre_result_fifo.sv
// Four-entry result queue taking up to two results per cycle.
module crre_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push0,
    input  logic              i_push1,
    input  crre_pkg::t_result i_data0,
    input  crre_pkg::t_result i_data1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_pop,
    output crre_pkg::t_result o_data
);

    crre_pkg::t_result r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + 2'(i_push0) + 2'(i_push1);
        n_rd_ptr = r_rd_ptr + 2'(pop);
        n_count  = r_count + 3'(i_push0) + 3'(i_push1) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[r_wr_ptr + 2'd1] <= i_data1;
        end
    end

endmodule

FILE: src/color_range_run_extractor.sv
// Color threshold run-length extractor: top level.
// A pixel waits in the input register until the result queue has room; its results are then written into the queue.
// Throughput: one pixel per cycle while the result queue has room; a pixel causing two results
// (run close plus frame summary) pushes both at once, absorbed by a four-entry result queue.
// Reset (synchronous, active low) restores register defaults and clears row, column,
// open run and area; no pixel or result is held across reset.
module color_range_run_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // ch0[7:0], ch1[15:8], ch2[23:16]
    input  logic        i_s_axis_tlast,   // end_of_row
    input  logic        i_s_axis_tuser,   // end_of_frame
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // run_row[11:0], run_first[23:12],
                                          // run_stop[36:24], frame_area[61:37],
                                          // region_kept[62], zero[63]
    output logic        o_m_axis_tlast,   // last_of_item
    output logic        o_m_axis_tuser,   // item_kind
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [crre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crre_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = crre_pkg::COORD_W;
    localparam int SW = crre_pkg::STOP_W;
    localparam int AW = crre_pkg::AREA_W;

    // configuration
    crre_pkg::t_match_cfg r_cfg;
    logic [AW-1:0]        r_min_area;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ch0_bounds <= 16'hFF00;
            r_cfg.ch1_bounds <= 16'hFF00;
            r_cfg.ch2_bounds <= 16'hFF00;
            r_cfg.hue_wrap   <= 1'b0;
            r_cfg.value_gain <= crre_pkg::GAIN_W'(256);
            r_min_area       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crre_pkg::REG_CH0_BOUNDS: r_cfg.ch0_bounds <= i_cfg_data[15:0];
                crre_pkg::REG_CH1_BOUNDS: r_cfg.ch1_bounds <= i_cfg_data[15:0];
                crre_pkg::REG_CH2_BOUNDS: r_cfg.ch2_bounds <= i_cfg_data[15:0];
                crre_pkg::REG_HUE_WRAP:   r_cfg.hue_wrap   <= i_cfg_data[0];
                crre_pkg::REG_VALUE_GAIN:
                    r_cfg.value_gain <= i_cfg_data[crre_pkg::GAIN_W-1:0];
                crre_pkg::REG_MIN_AREA:   r_min_area <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic        r_pv;
    logic [23:0] r_pix;
    logic        r_eor, r_eof;
    logic        go;
    logic        room;

    assign go              = r_pv && room;
    assign o_s_axis_tready = !r_pv || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_pv <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_pix <= i_s_axis_tdata;
            r_eor <= i_s_axis_tlast;
            r_eof <= i_s_axis_tuser;
        end
    end

    logic hit;

    crre_pixel_match u_match (
        .i_cfg (r_cfg),
        .i_ch0 (r_pix[7:0]),
        .i_ch1 (r_pix[15:8]),
        .i_ch2 (r_pix[23:16]),
        .o_hit (hit)
    );

    // frame state
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic          r_run_open, n_run_open;
    logic [CW-1:0] r_run_start, n_run_start;
    logic [AW-1:0] r_area, n_area;

    logic              row_end;
    logic              close_miss;
    logic              run_valid;
    logic [SW-1:0]     stop_raw;
    logic [SW-1:0]     first_ext;
    logic [CW-1:0]     first;
    logic [AW-1:0]     area_inc;
    crre_pkg::t_result run_rec, sum_rec;
    crre_pkg::t_result data0, data1;
    logic              push0, push1;

    always_comb begin
        row_end    = r_eor || r_eof;
        close_miss = !hit && r_run_open;
        run_valid  = close_miss || (hit && row_end);
        first      = r_run_open ? r_run_start : r_col;
        first_ext  = SW'(first);
        stop_raw   = close_miss ? SW'(r_col) : SW'(r_col) + SW'(1);
        area_inc   = (hit && (r_area < crre_pkg::AREA_SAT)) ? r_area + AW'(1) : r_area;

        run_rec              = '0;
        run_rec.item_kind    = crre_pkg::KIND_RUN;
        run_rec.run_row      = r_row;
        run_rec.run_first    = first;
        // stop is kept past first when the column has saturated
        run_rec.run_stop     = (stop_raw <= first_ext) ? first_ext + SW'(1) : stop_raw;
        run_rec.last_of_item = !r_eof;

        sum_rec              = '0;
        sum_rec.item_kind    = crre_pkg::KIND_SUMMARY;
        sum_rec.frame_area   = area_inc;
        sum_rec.region_kept  = (r_min_area == '0) || (area_inc >= r_min_area);
        sum_rec.last_of_item = 1'b1;

        data0 = run_valid ? run_rec : sum_rec;
        data1 = sum_rec;
        push0 = go && (run_valid || r_eof);
        push1 = go && run_valid && r_eof;

        n_area      = area_inc;
        n_run_start = (hit && !r_run_open) ? r_col : r_run_start;
        if (row_end) begin
            n_col      = '0;
            n_row      = (r_row < crre_pkg::ROW_LAST) ? r_row + CW'(1) : r_row;
            n_run_open = 1'b0;
        end else begin
            n_col      = (r_col < crre_pkg::COL_LAST) ? r_col + CW'(1) : r_col;
            n_row      = r_row;
            n_run_open = hit;
        end
        if (r_eof) begin
            n_row       = '0;
            n_col       = '0;
            n_area      = '0;
            n_run_open  = 1'b0;
            n_run_start = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
            r_area      <= '0;
        end else if (go) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_run_open  <= n_run_open;
            r_run_start <= n_run_start;
            r_area      <= n_area;
        end
    end

    crre_pkg::t_result out_rec;

    crre_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_data0 (data0),
        .i_data1 (data1),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_pop   (i_m_axis_tready),
        .o_data  (out_rec)
    );

    assign o_m_axis_tdata = {1'b0, out_rec.region_kept, out_rec.frame_area,
                             out_rec.run_stop, out_rec.run_first, out_rec.run_row};
    assign o_m_axis_tlast = out_rec.last_of_item;
    assign o_m_axis_tuser = out_rec.item_kind;

endmodule

FILE: verif/crre_checker.sv
// Checker for the color range run extractor: predicts runs and frame summaries and compares.
module crre_checker
    import crre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel channel
    input  logic                  i_pix_valid,
    input  logic                  i_pix_ready,
    input  logic [23:0]           i_pix_data,    // ch0[7:0], ch1[15:8], ch2[23:16]
    input  logic                  i_pix_last,    // end_of_row
    input  logic                  i_pix_user,    // end_of_frame
    // result channel
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [63:0]           i_res_data,
    input  logic                  i_res_last,
    input  logic                  i_res_user,
    // register writes
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_runs,
    output int                    o_summaries
);

    localparam int PRINT_LIMIT = 40;

    logic [15:0]        bounds [0:2];
    logic               hue_wrap;
    logic [GAIN_W-1:0]  gain;
    logic [AREA_W-1:0]  min_area;

    logic [COORD_W-1:0] col_count;
    logic [COORD_W-1:0] row_count;
    logic [COORD_W-1:0] run_start;
    logic               run_open;
    logic [AREA_W-1:0]  area_total;

    t_result            expected_results [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 pending_count = 0;
    int                 runs_seen = 0;
    int                 summaries_seen = 0;

    assign o_errors    = mismatches;
    assign o_pending   = pending_count;
    assign o_runs      = runs_seen;
    assign o_summaries = summaries_seen;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("crre_checker: result %0d: %s got %0d, want %0d",
                     results_seen, what, got, want);
    endtask

    function automatic logic in_range(input logic [7:0] v, input logic [15:0] b,
                                      input logic wrap);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = b[7:0];
        hi = b[15:8];
        if (wrap && lo > hi)
            return v >= lo || v <= hi;
        return v >= lo && v <= hi;
    endfunction

    function automatic t_result run_record(input logic [STOP_W-1:0] stop);
        t_result r;
        r = '0;
        r.item_kind = KIND_RUN;
        r.run_row   = row_count;
        r.run_first = run_start;
        // saturated column: stop must still lie past the first column
        r.run_stop  = (stop <= {1'b0, run_start}) ? {1'b0, run_start} + 1'b1 : stop;
        return r;
    endfunction

    function automatic void predict_pixel(input logic [23:0] px, input logic eor,
                                          input logic eof);
        logic [19:0]        product;
        logic [7:0]         value;
        logic               hit;
        logic [COORD_W-1:0] x;
        t_result            found [0:1];
        t_result            summary;
        int                 n;
        n = 0;
        x = col_count;
        product = 20'(px[23:16]) * 20'(gain) + 20'd128;
        value = (product[19:8] > 12'd255) ? 8'hFF : product[15:8];
        hit = in_range(px[7:0], bounds[0], hue_wrap) &&
              in_range(px[15:8], bounds[1], 1'b0) &&
              in_range(value, bounds[2], 1'b0);

        if (hit) begin
            if (area_total != AREA_SAT)
                area_total = area_total + 1'b1;
            if (!run_open) begin
                run_open  = 1'b1;
                run_start = x;
            end
        end else if (run_open) begin
            found[n] = run_record({1'b0, x});
            n++;
            run_open = 1'b0;
        end

        if (eor || eof) begin
            if (run_open) begin
                found[n] = run_record({1'b0, x} + 1'b1);
                n++;
                run_open = 1'b0;
            end
            col_count = '0;
            if (row_count != ROW_LAST)
                row_count = row_count + 1'b1;
        end else if (col_count != COL_LAST) begin
            col_count = col_count + 1'b1;
        end

        if (eof) begin
            summary = '0;
            summary.item_kind   = KIND_SUMMARY;
            summary.frame_area  = area_total;
            summary.region_kept = (min_area == '0) || (area_total >= min_area);
            found[n] = summary;
            n++;
            row_count  = '0;
            col_count  = '0;
            area_total = '0;
            run_open   = 1'b0;
            run_start  = '0;
        end

        if (n > 0)
            found[n-1].last_of_item = 1'b1;
        for (int k = 0; k < n; k++)
            expected_results.push_back(found[k]);
    endfunction

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected, kind", 32'(i_res_user), 32'd0);
        end else begin
            want = expected_results.pop_front();
            if (want.item_kind == KIND_RUN)
                runs_seen++;
            else
                summaries_seen++;
            if (i_res_user !== want.item_kind)
                report_mismatch("item_kind", 32'(i_res_user), 32'(want.item_kind));
            if (i_res_data[11:0] !== want.run_row)
                report_mismatch("run_row", 32'(i_res_data[11:0]), 32'(want.run_row));
            if (i_res_data[23:12] !== want.run_first)
                report_mismatch("run_first", 32'(i_res_data[23:12]), 32'(want.run_first));
            if (i_res_data[36:24] !== want.run_stop)
                report_mismatch("run_stop", 32'(i_res_data[36:24]), 32'(want.run_stop));
            if (i_res_data[61:37] !== want.frame_area)
                report_mismatch("frame_area", 32'(i_res_data[61:37]), 32'(want.frame_area));
            if (i_res_data[62] !== want.region_kept)
                report_mismatch("region_kept", 32'(i_res_data[62]), 32'(want.region_kept));
            if (i_res_data[63] !== 1'b0)
                report_mismatch("pad bit", 32'(i_res_data[63]), 32'd0);
            if (i_res_last !== want.last_of_item)
                report_mismatch("last_of_item", 32'(i_res_last), 32'(want.last_of_item));
        end
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bounds[0]  = 16'hFF00;
            bounds[1]  = 16'hFF00;
            bounds[2]  = 16'hFF00;
            hue_wrap   = 1'b0;
            gain       = GAIN_W'(256);
            min_area   = '0;
            col_count  = '0;
            row_count  = '0;
            run_start  = '0;
            run_open   = 1'b0;
            area_total = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CH0_BOUNDS: bounds[0] = i_cfg_data[15:0];
                    REG_CH1_BOUNDS: bounds[1] = i_cfg_data[15:0];
                    REG_CH2_BOUNDS: bounds[2] = i_cfg_data[15:0];
                    REG_HUE_WRAP:   hue_wrap  = i_cfg_data[0];
                    REG_VALUE_GAIN: gain      = i_cfg_data[GAIN_W-1:0];
                    REG_MIN_AREA:   min_area  = i_cfg_data[AREA_W-1:0];
                    default: ;
                endcase
            end
            // predict before checking: a pixel's results never leave on its own edge
            if (i_pix_valid && i_pix_ready)
                predict_pixel(i_pix_data, i_pix_last, i_pix_user);
            if (i_res_valid && i_res_ready)
                check_result();
        end
        pending_count = expected_results.size();
    end

endmodule

FILE: verif/tb.sv
// Testbench top: drives pixels, register writes and output back-pressure, gives the verdict.
module tb;
    import crre_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT    = 4000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata = '0;
    logic                  i_s_axis_tlast = 1'b0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [63:0]           o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors;
    int pending;
    int runs_seen;
    int summaries_seen;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int pixels_sent = 0;
    int settings_loaded = 0;

    // current match window, used only to aim stimulus at hits
    logic [15:0]       cur_bounds [0:2];
    logic              cur_wrap;
    logic [GAIN_W-1:0] cur_gain;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    color_range_run_extractor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    crre_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_s_axis_tvalid),
        .i_pix_ready (o_s_axis_tready),
        .i_pix_data  (i_s_axis_tdata),
        .i_pix_last  (i_s_axis_tlast),
        .i_pix_user  (i_s_axis_tuser),
        .i_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .i_res_data  (o_m_axis_tdata),
        .i_res_last  (o_m_axis_tlast),
        .i_res_user  (o_m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_runs      (runs_seen),
        .o_summaries (summaries_seen)
    );

    // result sink: random stalls, plus a long hold-off whenever one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                holds_done++;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        #RUN_LIMIT;
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic eor, input logic eof);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {c2, c1, c0};
        i_s_axis_tlast  <= eor;
        i_s_axis_tuser  <= eof;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a pixel that causes no result may still be in the pipe
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] b0, input logic [15:0] b1,
                                 input logic [15:0] b2, input logic wrap,
                                 input logic [GAIN_W-1:0] gain,
                                 input logic [AREA_W-1:0] area);
        wait_drained();
        write_reg(REG_CH0_BOUNDS, CFG_DATA_W'(b0));
        write_reg(REG_CH1_BOUNDS, CFG_DATA_W'(b1));
        write_reg(REG_CH2_BOUNDS, CFG_DATA_W'(b2));
        write_reg(REG_HUE_WRAP, CFG_DATA_W'(wrap));
        write_reg(REG_VALUE_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_MIN_AREA, CFG_DATA_W'(area));
        i_cfg_valid <= 1'b0;
        cur_bounds[0] = b0;
        cur_bounds[1] = b1;
        cur_bounds[2] = b2;
        cur_wrap      = wrap;
        cur_gain      = gain;
        settings_loaded++;
    endtask

    function automatic logic [15:0] random_bounds();
        logic [7:0] lo;
        case ($urandom_range(3))
            0: return 16'hFF00;
            1: return 16'($urandom);
            default: begin
                lo = 8'($urandom_range(220));
                return {8'($urandom_range(255, lo)), lo};
            end
        endcase
    endfunction

    task automatic load_random_settings();
        logic [GAIN_W-1:0] gain;
        logic [AREA_W-1:0] area;
        case ($urandom_range(4))
            0: gain = GAIN_W'(1);
            1: gain = GAIN_W'(256);
            2: gain = GAIN_W'(4095);
            default: gain = GAIN_W'($urandom_range(4095, 1));
        endcase
        case ($urandom_range(3))
            0: area = '0;
            1: area = AREA_W'(16777216);
            default: area = AREA_W'($urandom_range(40, 1));
        endcase
        load_settings(random_bounds(), random_bounds(), random_bounds(),
                      1'($urandom_range(1)), gain, area);
    endtask

    function automatic logic [7:0] pick_in(input logic [15:0] b, input logic wrap);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = b[7:0];
        hi = b[15:8];
        if (lo <= hi)
            return 8'($urandom_range(hi, lo));
        if (!wrap)
            return 8'($urandom);
        if ($urandom_range(1))
            return 8'($urandom_range(255, lo));
        return 8'($urandom_range(hi, 0));
    endfunction

    // channel 2 is tested after gain, so search for a raw value that lands inside
    function automatic logic [7:0] pick_value();
        logic [7:0]  c;
        logic [19:0] p;
        logic [7:0]  v;
        c = 8'($urandom);
        for (int k = 0; k < 16; k++) begin
            c = 8'($urandom);
            p = 20'(c) * 20'(cur_gain) + 20'd128;
            v = (p[19:8] > 12'd255) ? 8'hFF : p[15:8];
            if (v >= cur_bounds[2][7:0] && v <= cur_bounds[2][15:8])
                return c;
        end
        return c;
    endfunction

    task automatic send_matched(input logic eor, input logic eof);
        send_pixel(pick_in(cur_bounds[0], cur_wrap), pick_in(cur_bounds[1], 1'b0),
                   pick_value(), eor, eof);
    endtask

    task automatic send_frame(input int rows, input int width_max, input int hit_pct);
        int   width;
        logic eor;
        logic eof;
        for (int r = 0; r < rows; r++) begin
            width = $urandom_range(width_max, 1);
            for (int c = 0; c < width; c++) begin
                eor = (c == width - 1);
                eof = eor && (r == rows - 1);
                // broken frame: an early frame end anywhere
                if ($urandom_range(99) < 2)
                    eof = 1'b1;
                if (eof)
                    eor = 1'($urandom_range(1));
                if ($urandom_range(99) < hit_pct)
                    send_matched(eor, eof);
                else
                    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), eor, eof);
                if (eof)
                    return;
            end
        end
    endtask

    task automatic random_phase(input int tx, input int rx, input int count,
                                input logic squeeze);
        int goal;
        load_random_settings();
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        if (squeeze)
            hold_requests++;
        goal = pixels_sent + count;
        while (pixels_sent < goal)
            send_frame($urandom_range(6, 1), $urandom_range(16, 1), $urandom_range(95, 30));
    endtask

    initial begin
        cur_bounds[0] = 16'hFF00;
        cur_bounds[1] = 16'hFF00;
        cur_bounds[2] = 16'hFF00;
        cur_wrap      = 1'b0;
        cur_gain      = GAIN_W'(256);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bound edges, misses per channel, runs closing on miss, row end and frame end
        load_settings(16'h8040, 16'hFF10, 16'hC020, 1'b0, GAIN_W'(256), AREA_W'(3));
        send_pixel(8'h40, 8'h10, 8'h20, 1'b0, 1'b0);
        send_pixel(8'h80, 8'hFF, 8'hC0, 1'b0, 1'b0);
        send_pixel(8'h3F, 8'h80, 8'h80, 1'b0, 1'b0);
        send_pixel(8'h81, 8'h80, 8'h80, 1'b0, 1'b0);
        send_pixel(8'h60, 8'h0F, 8'h80, 1'b0, 1'b0);
        send_pixel(8'h60, 8'h80, 8'h1F, 1'b0, 1'b0);
        send_pixel(8'h60, 8'h80, 8'hC1, 1'b0, 1'b0);
        send_pixel(8'h60, 8'h80, 8'h80, 1'b1, 1'b0);
        send_pixel(8'h60, 8'h80, 8'h80, 1'b0, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'h60, 8'h80, 8'h80, 1'b0, 1'b1);
        send_pixel(8'h60, 8'h80, 8'h80, 1'b0, 1'b0);
        send_pixel(8'h00, 8'h80, 8'h80, 1'b1, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);

        // wrapped hue, zero gain, minimum area of 16777216
        load_settings(16'h10F0, 16'hFF00, 16'h0000, 1'b1, GAIN_W'(0), AREA_W'(16777216));
        send_pixel(8'hF0, 8'h00, 8'hFF, 1'b0, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'h01, 1'b0, 1'b0);
        send_pixel(8'h00, 8'h55, 8'h80, 1'b0, 1'b0);
        send_pixel(8'h10, 8'hAA, 8'h7F, 1'b0, 1'b0);
        send_pixel(8'h11, 8'h00, 8'h00, 1'b0, 1'b0);
        send_pixel(8'hEF, 8'h00, 8'h00, 1'b0, 1'b0);
        send_pixel(8'hF0, 8'h00, 8'h00, 1'b0, 1'b1);

        // largest gain saturates channel 2; hue window wraps to just 0 and 255
        load_settings(16'h00FF, 16'hFF00, 16'hFFFF, 1'b1, GAIN_W'(4095), AREA_W'(1));
        send_pixel(8'hFF, 8'h12, 8'h10, 1'b0, 1'b0);
        send_pixel(8'h00, 8'hED, 8'h0F, 1'b0, 1'b0);
        send_pixel(8'h00, 8'h34, 8'hFF, 1'b1, 1'b1);

        random_phase(0, 0, 150, 1'b1);
        random_phase(46, 0, 150, 1'b0);
        random_phase(0, 46, 150, 1'b0);
        random_phase(37, 37, 150, 1'b0);

        rx_stall_pct = 0;
        wait_drained();
        $display("tb: %0d pixels under %0d register settings; %0d runs, %0d frame summaries",
                 pixels_sent, settings_loaded, runs_seen, summaries_seen);
        $display("tb: bound edges, wrapped hue, gain 0 to max, broken frames, long hold-off");
        if (errors == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
